// ----- hdl/imhq_pkg.sv -----
// Package for the indexed min-heap queue: sizes, request and status codes,
// beat structs and the key comparison. No dependencies.
`default_nettype none
package imhq_pkg;
  localparam int HeapDepth = 256;
  localparam int PayloadBits = 16;
  localparam int AddrW = $clog2(HeapDepth);
  localparam int CntW = AddrW + 1;

  typedef enum logic [1:0] {
    REQ_INSERT  = 2'd0,
    REQ_EXTRACT = 2'd1,
    REQ_REMOVE  = 2'd2,
    REQ_PEEK    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_BAD_HDL = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] key_s;
    logic signed [31:0] key_t;
    logic [15:0]        vertex_ref;
    logic [7:0]         entry_handle;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [7:0]         new_handle;
    logic [15:0]        min_vertex_ref;
    logic signed [31:0] min_key_s;
    logic signed [31:0] min_key_t;
  } out_item_t;

  typedef struct packed {
    logic [PayloadBits-1:0] payload;
    logic signed [31:0]     key_s;
    logic signed [31:0]     key_t;
    logic [AddrW-1:0]       handle;
  } slot_t;

  localparam int SlotW = $bits(slot_t);

  // strict lexicographic order on (key_s, key_t)
  function automatic logic key_less(input slot_t a, input slot_t b);
    return (a.key_s < b.key_s) || ((a.key_s == b.key_s) && (a.key_t < b.key_t));
  endfunction
endpackage
`default_nettype wire

// ----- hdl/imhq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module imhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// ----- hdl/indexed_min_heap_queue_core.sv -----
// Indexed min-heap queue top level: sequencer, heap slot, handle position and
// free-handle RAMs. Depends on imhq_pkg and imhq_ram.
//
//  channel | dir | handshake          | payload
//  in      | in  | in_valid/in_ready  | in_item  (imhq_pkg::in_item_t)
//  out     | out | out_valid/out_ready| out_item (imhq_pkg::out_item_t)
//
// One request at a time; a sift step goes through S_UP and S_UP_CMP per level going up
// and S_DN, S_DN_L and S_DN_R going down (one slot RAM read port, registered).
// Reset clears counts and handle live bits at once; the RAMs need no clearing.
// A finished result waits in the output register; the next request is taken
// meanwhile and only its completion waits for the register to empty.
`default_nettype none
module indexed_min_heap_queue_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire imhq_pkg::in_item_t in_item,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      imhq_pkg::out_item_t out_item
);
  import imhq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_FREE_WAIT, S_TOP_WAIT, S_POS_WAIT, S_LAST_WAIT,
    S_UP, S_UP_CMP, S_DN, S_DN_L, S_DN_R, S_DONE
  } state_t;

  state_t           state;
  req_t             req;
  in_item_t         item;
  out_item_t        res;
  slot_t            cur, lreg;
  logic [AddrW-1:0] idx;
  logic             lifted;
  logic             reuse;
  logic [CntW-1:0]  count, issued, free_cnt;
  logic [HeapDepth-1:0] live;

  // RAM ports
  logic             slot_we;
  logic [AddrW-1:0] slot_waddr, slot_raddr;
  slot_t            slot_wdata, slot_rd;
  logic [AddrW-1:0] pos_raddr, pos_rd;
  logic             free_we;
  logic [AddrW-1:0] free_raddr, free_rd;
  logic [AddrW-1:0] push_h;

  imhq_ram #(.WIDTH(SlotW), .DEPTH(HeapDepth)) u_slot (
    .clk, .wr_en(slot_we), .wr_addr(slot_waddr), .wr_data(slot_wdata),
    .rd_addr(slot_raddr), .rd_data(slot_rd)
  );
  // handle -> slot index, written with every slot placement
  imhq_ram #(.WIDTH(AddrW), .DEPTH(HeapDepth)) u_pos (
    .clk, .wr_en(slot_we), .wr_addr(slot_wdata.handle), .wr_data(slot_waddr),
    .rd_addr(pos_raddr), .rd_data(pos_rd)
  );
  imhq_ram #(.WIDTH(AddrW), .DEPTH(HeapDepth)) u_free (
    .clk, .wr_en(free_we), .wr_addr(free_cnt[AddrW-1:0]), .wr_data(push_h),
    .rd_addr(free_raddr), .rd_data(free_rd)
  );

  logic [AddrW:0]   lchild, rchild;
  logic [AddrW-1:0] parent;
  logic             up_less, up_end, up_to_dn, l_less, r_less, r_ok;
  logic [CntW-1:0]  count_dec;
  slot_t            best;
  slot_t            new_slot;
  logic [AddrW-1:0] new_h;

  assign lchild    = {idx, 1'b1};
  assign rchild    = lchild + (AddrW+1)'(1);
  assign parent    = (idx - AddrW'(1)) >> 1;
  assign count_dec = count - CntW'(1);
  assign r_ok      = {1'b0, rchild} < {1'b0, count};
  assign up_less   = key_less(cur, slot_rd);
  assign up_end    = (state == S_UP && idx == '0) || (state == S_UP_CMP && !up_less);
  assign up_to_dn  = up_end && !lifted && (req == REQ_REMOVE);
  assign l_less    = (state == S_DN_L) ? key_less(slot_rd, cur) : key_less(lreg, cur);
  assign best      = l_less ? lreg : cur;
  assign r_less    = key_less(slot_rd, best);
  assign in_ready  = (state == S_IDLE);
  assign free_we   = (state == S_TOP_WAIT && req == REQ_EXTRACT && !free_cnt[AddrW])
                  || (state == S_POS_WAIT && !free_cnt[AddrW]);
  // extract pushes the root's handle, straight from the read port
  assign push_h    = (state == S_TOP_WAIT) ? slot_rd.handle : lreg.handle;
  assign new_h     = reuse ? free_rd : issued[AddrW-1:0] - AddrW'(1);
  assign new_slot  = '{payload: item.vertex_ref[PayloadBits-1:0], key_s: item.key_s,
                       key_t: item.key_t, handle: new_h};

  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = idx;
    slot_wdata = cur;
    slot_raddr = '0;
    pos_raddr  = in_item.entry_handle;
    free_raddr = free_cnt[AddrW-1:0] - AddrW'(1);
    unique case (state)
      S_TOP_WAIT:  slot_raddr = count_dec[AddrW-1:0];
      S_POS_WAIT:  slot_raddr = count_dec[AddrW-1:0];
      S_UP:        slot_raddr = parent;
      S_DN:        slot_raddr = lchild[AddrW-1:0];
      S_DN_L:      slot_raddr = rchild[AddrW-1:0];
      default:     slot_raddr = '0;
    endcase
    if (state == S_UP_CMP && up_less) begin
      slot_we    = 1'b1;
      slot_wdata = slot_rd;
    end else if (up_end && !up_to_dn) begin
      slot_we = 1'b1;
    end else if (state == S_DN && {1'b0, lchild} >= {1'b0, count}) begin
      slot_we = 1'b1;
    end else if (state == S_DN_L && !r_ok) begin
      slot_we    = 1'b1;
      slot_wdata = l_less ? slot_rd : cur;
    end else if (state == S_DN_R) begin
      slot_we    = 1'b1;
      slot_wdata = r_less ? slot_rd : best;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      issued    <= '0;
      free_cnt  <= '0;
      live      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item   <= in_item;
            req    <= req_t'(in_item.req_type);
            lifted <= 1'b0;
            lreg.handle <= in_item.entry_handle;
            unique case (req_t'(in_item.req_type))
              REQ_INSERT: begin
                if (count == CntW'(HeapDepth)) begin
                  res   <= '{status: ST_FULL, default: '0};
                  state <= S_DONE;
                end else if (free_cnt != '0) begin
                  res      <= '0;
                  reuse    <= 1'b1;
                  free_cnt <= free_cnt - CntW'(1);
                  state    <= S_FREE_WAIT;
                end else begin
                  res    <= '0;
                  reuse  <= 1'b0;
                  issued <= issued + CntW'(1);
                  state  <= S_FREE_WAIT;
                end
              end
              REQ_EXTRACT, REQ_PEEK: begin
                if (count == '0) begin
                  res   <= '{status: ST_EMPTY, default: '0};
                  state <= S_DONE;
                end else begin
                  res   <= '0;
                  state <= S_TOP_WAIT;
                end
              end
              REQ_REMOVE: begin
                if (!live[in_item.entry_handle]) begin
                  res   <= '{status: ST_BAD_HDL, default: '0};
                  state <= S_DONE;
                end else begin
                  res   <= '0;
                  state <= S_POS_WAIT;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_FREE_WAIT: begin
          // take the popped handle, or the one just issued
          cur            <= new_slot;
          res.new_handle <= new_h;
          live[new_h]    <= 1'b1;
          idx    <= count[AddrW-1:0];
          count  <= count + CntW'(1);
          lifted <= 1'b1;
          state  <= S_UP;
        end
        S_TOP_WAIT: begin
          res.min_vertex_ref <= 16'(slot_rd.payload);
          res.min_key_s      <= slot_rd.key_s;
          res.min_key_t      <= slot_rd.key_t;
          if (req == REQ_PEEK) begin
            state <= S_DONE;
          end else begin
            lreg.handle          <= slot_rd.handle;
            live[slot_rd.handle] <= 1'b0;
            idx                  <= '0;
            state                <= S_LAST_WAIT;
          end
        end
        S_POS_WAIT: begin
          live[lreg.handle] <= 1'b0;
          idx               <= pos_rd;
          state             <= S_LAST_WAIT;
        end
        S_LAST_WAIT: begin
          // free stack push took place in the previous cycle
          if (!free_cnt[AddrW]) begin
            free_cnt <= free_cnt + CntW'(1);
          end
          count <= count_dec;
          cur   <= slot_rd;
          if (count_dec == '0 || (req == REQ_REMOVE && {1'b0, idx} == count_dec)) begin
            state <= S_DONE;
          end else if (req == REQ_EXTRACT) begin
            state <= S_DN;
          end else begin
            state <= S_UP;
          end
        end
        S_UP: begin
          if (idx == '0) begin
            state <= up_to_dn ? S_DN : S_DONE;
          end else begin
            state <= S_UP_CMP;
          end
        end
        S_UP_CMP: begin
          if (up_less) begin
            idx    <= parent;
            lifted <= 1'b1;
            state  <= S_UP;
          end else begin
            state <= up_to_dn ? S_DN : S_DONE;
          end
        end
        S_DN: begin
          state <= ({1'b0, lchild} >= {1'b0, count}) ? S_DONE : S_DN_L;
        end
        S_DN_L: begin
          lreg <= slot_rd;
          if (r_ok) begin
            state <= S_DN_R;
          end else if (l_less) begin
            idx   <= lchild[AddrW-1:0];
            state <= S_DN;
          end else begin
            state <= S_DONE;
          end
        end
        S_DN_R: begin
          if (r_less) begin
            idx   <= rchild[AddrW-1:0];
            state <= S_DN;
          end else if (l_less) begin
            idx   <= lchild[AddrW-1:0];
            state <= S_DN;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_item  <= res;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // live handles match the entry count, and every issued handle is live or stacked
  a_live_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ($countones(live) == int'(count)))
    else $error("live handle count differs from entry count");
  a_handle_sum: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (issued == count + free_cnt))
    else $error("issued handles not accounted for");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(HeapDepth))
    else $error("entry count beyond heap depth");
endmodule
`default_nettype wire
